// ===== hdl/tst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_pkg
// Shared widths, constants and sequencer states for the Taylor sine/tangent
// block.
// ----------------------------------------------------------------------------
package tst_pkg;

    localparam int FRAC_BITS   = 20;
    localparam int MAX_TERMS_D = 16;

    localparam int ANGLE_W = 23;
    localparam int OUT_W   = 22;
    localparam int TAN_W   = 32;
    localparam int TC_W    = 5;
    localparam int THR_W   = 10;
    localparam int CFG_W   = 10;

    localparam int TERM_W  = 30;
    localparam int X2_W    = 26;
    localparam int SUM_W   = 34;
    localparam int MAG_W   = 22;
    localparam int S2_W    = 23;
    localparam int ROOT_W  = 21;
    localparam int REM_W   = 22;
    localparam int SUB_W   = 23;
    localparam int DQ_W    = 42;
    localparam int DIVR_W  = 21;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 64;
    localparam int CNT_W   = 6;

    localparam int DIV_STEPS  = DQ_W;
    localparam int SQRT_STEPS = ROOT_W;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] HALF_PI_W =
        (PI_Q60 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS);
    localparam logic [63:0] THREE_HALF_PI_W =
        (64'd3 * PI_Q60 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS);
    localparam logic [ANGLE_W-1:0] HALF_PI       = HALF_PI_W[ANGLE_W-1:0];
    localparam logic [ANGLE_W-1:0] THREE_HALF_PI = THREE_HALF_PI_W[ANGLE_W-1:0];

    localparam logic [0:0] REG_TERM_COUNT = 1'b0;
    localparam logic [0:0] REG_COS_THRESH = 1'b1;

    localparam logic [TC_W-1:0]  TERM_COUNT_RST = 5'd10;
    localparam logic [THR_W-1:0] COS_THRESH_RST = 10'd10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X2,
        ST_GET_X2,
        ST_TERM_MUL,
        ST_TERM_LOAD,
        ST_TERM_DIV,
        ST_TERM_ACC,
        ST_SINE_MUL,
        ST_SQRT_LOAD,
        ST_SQRT,
        ST_TAN_LOAD,
        ST_TAN_DIV,
        ST_FINISH
    } state_t;

endpackage

// ===== hdl/taylor_sine_tangent_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taylor_sine_tangent_top
// Sine by Taylor series, cosine by the Pythagorean identity, tangent as the
// quotient, all on one shared multiplier and one shared compare/subtract unit.
// ----------------------------------------------------------------------------
// One angle (unsigned Q3.20 radians) is taken while in_stall is low and gives
// one transaction of sine, cosine, tangent and an infinite flag. With n series
// terms (term_count capped at MAX_TERMS, at least one), the sequencer runs one
// multiply and one bit-serial division per series term beyond the first, then
// squares the sine, takes the square root and runs the tangent division; the
// next angle can be taken in the cycle after the result is loaded. When the
// tangent is infinite the tangent division is skipped. The bit-serial divider
// serves each term and the tangent. in_stall stays high until the result is
// loaded into the output register, so a stalled output holds the block.
module taylor_sine_tangent_top
    import tst_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_D
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [ANGLE_W-1:0]        angle,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [OUT_W-1:0]   sine,
    output logic signed [OUT_W-1:0]   cosine,
    output logic signed [TAN_W-1:0]   tangent,
    output logic                      tangent_infinite,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_index,
    input  logic [CFG_W-1:0]          cfg_data
);

    localparam int CW   = $clog2(MAX_TERMS + 1);
    localparam int D_W  = 2 * (CW + 1);

    state_t state_reg, state_next;

    logic [TC_W-1:0]          tc_reg;
    logic [THR_W-1:0]         thr_reg;
    logic                     out_valid_reg, out_valid_next;

    logic [ANGLE_W-1:0]       x_reg, x_next;
    logic [X2_W-1:0]          x2_reg, x2_next;
    logic [TERM_W-1:0]        t_reg, t_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [CW-1:0]            i_reg, i_next;
    logic [CW-1:0]            n_reg, n_next;
    logic [PROD_W-1:0]        prod_reg;
    logic [DQ_W-1:0]          dq_reg, dq_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [DIVR_W-1:0]        divr_reg, divr_next;
    logic [DQ_W-1:0]          v_reg, v_next;
    logic [ROOT_W-1:0]        root_reg, root_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     inf_reg, inf_next;

    logic signed [OUT_W-1:0]  sine_reg, sine_next;
    logic signed [OUT_W-1:0]  cos_reg, cos_next;
    logic signed [TAN_W-1:0]  tan_reg, tan_next;
    logic                     tinf_reg, tinf_next;

    logic                     in_acc;
    logic                     load_out;
    logic [MUL_W-1:0]         mul_a, mul_b;
    logic [SUB_W-1:0]         sub_a, sub_b;
    logic [SUB_W:0]           sub_diff;
    logic                     sub_ge;
    logic signed [OUT_W-1:0]  sine_sat;
    logic signed [OUT_W:0]    sine_ext;
    logic [OUT_W:0]           mag_ext;
    logic [MAG_W-1:0]         smag;
    logic [S2_W-1:0]          s2;
    logic [S2_W-1:0]          cdiff;
    logic [D_W-1:0]           d_val;
    logic [CW:0]              i_dbl;
    logic [CW-1:0]            i_inc;
    logic                     cneg;
    logic                     tneg;
    logic [TAN_W:0]           qsat;
    logic [OUT_W:0]           cmag_ext;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign sine             = sine_reg;
    assign cosine           = cos_reg;
    assign tangent          = tan_reg;
    assign tangent_infinite = tinf_reg;

    assign load_out = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);
    assign i_inc    = i_reg + CW'(1);
    assign i_dbl    = {i_reg, 1'b0};
    assign d_val    = D_W'(i_dbl) * D_W'(i_dbl + (CW + 1)'(1));

    always_comb
    begin
        if (sum_reg > SUM_W'(signed'(2097151)))
            sine_sat = OUT_W'(signed'(2097151));
        else if (sum_reg < -SUM_W'(signed'(2097152)))
            sine_sat = OUT_W'(signed'(-2097152));
        else
            sine_sat = sum_reg[OUT_W-1:0];
    end

    assign sine_ext = {sine_sat[OUT_W-1], sine_sat};
    assign mag_ext  = sine_sat[OUT_W-1] ? (OUT_W + 1)'(-sine_ext) : (OUT_W + 1)'(sine_ext);
    assign smag     = mag_ext[MAG_W-1:0];
    assign s2       = prod_reg[FRAC_BITS +: S2_W];
    assign cdiff    = (S2_W'(1) << FRAC_BITS) > s2 ? (S2_W'(1) << FRAC_BITS) - s2
                                                    : s2 - (S2_W'(1) << FRAC_BITS);
    assign cneg     = (x_reg > HALF_PI) && (x_reg < THREE_HALF_PI);
    assign tneg     = sine_sat[OUT_W-1] ^ cneg;
    assign cmag_ext = {2'b00, root_reg};

    // shared compare/subtract: divider step or square-root step
    always_comb
    begin
        if (state_reg == ST_SQRT)
        begin
            sub_a = {rem_reg[SUB_W-3:0], v_reg[DQ_W-1 -: 2]};
            sub_b = {root_reg, 2'b01};
        end
        else
        begin
            sub_a = {rem_reg, dq_reg[DQ_W-1]};
            sub_b = SUB_W'(divr_reg);
        end
    end

    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = !sub_diff[SUB_W];

    always_comb
    begin
        case (state_reg)
            ST_MUL_X2:   begin mul_a = MUL_W'(x_reg); mul_b = MUL_W'(x_reg); end
            ST_TERM_MUL: begin mul_a = MUL_W'(t_reg); mul_b = MUL_W'(x2_reg); end
            default:     begin mul_a = MUL_W'(smag);  mul_b = MUL_W'(smag);   end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_acc) state_next = ST_MUL_X2;
            ST_MUL_X2:    state_next = ST_GET_X2;
            ST_GET_X2:    state_next = (n_reg > CW'(1)) ? ST_TERM_MUL : ST_SINE_MUL;
            ST_TERM_MUL:  state_next = ST_TERM_LOAD;
            ST_TERM_LOAD: state_next = ST_TERM_DIV;
            ST_TERM_DIV:  if (cnt_reg == CNT_W'(1)) state_next = ST_TERM_ACC;
            ST_TERM_ACC:  state_next = (i_inc < n_reg) ? ST_TERM_MUL : ST_SINE_MUL;
            ST_SINE_MUL:  state_next = ST_SQRT_LOAD;
            ST_SQRT_LOAD: state_next = ST_SQRT;
            ST_SQRT:      if (cnt_reg == CNT_W'(1)) state_next = ST_TAN_LOAD;
            ST_TAN_LOAD:  state_next = inf_next ? ST_FINISH : ST_TAN_DIV;
            ST_TAN_DIV:   if (cnt_reg == CNT_W'(1)) state_next = ST_FINISH;
            ST_FINISH:    if (load_out) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        x_next    = x_reg;
        x2_next   = x2_reg;
        t_next    = t_reg;
        sum_next  = sum_reg;
        i_next    = i_reg;
        n_next    = n_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        divr_next = divr_reg;
        v_next    = v_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        inf_next  = inf_reg;
        qsat      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                x_next   = angle;
                t_next   = TERM_W'(angle);
                sum_next = SUM_W'(angle);
                i_next   = CW'(1);
                if (32'(tc_reg) > 32'(MAX_TERMS))
                    n_next = CW'(MAX_TERMS);
                else
                    n_next = CW'(tc_reg);
            end
            ST_GET_X2:
                x2_next = prod_reg[FRAC_BITS +: X2_W];
            ST_TERM_LOAD:
            begin
                dq_next   = prod_reg[FRAC_BITS +: DQ_W];
                rem_next  = '0;
                divr_next = DIVR_W'(d_val);
                cnt_next  = CNT_W'(DIV_STEPS);
            end
            ST_TERM_DIV, ST_TAN_DIV:
            begin
                rem_next = sub_ge ? sub_diff[REM_W-1:0] : sub_a[REM_W-1:0];
                dq_next  = {dq_reg[DQ_W-2:0], sub_ge};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            ST_TERM_ACC:
            begin
                t_next = dq_reg[TERM_W-1:0];
                if (i_reg[0])
                    sum_next = sum_reg - SUM_W'(dq_reg[TERM_W-1:0]);
                else
                    sum_next = sum_reg + SUM_W'(dq_reg[TERM_W-1:0]);
                i_next = i_inc;
            end
            ST_SQRT_LOAD:
            begin
                v_next    = DQ_W'(cdiff) << FRAC_BITS;
                rem_next  = '0;
                root_next = '0;
                cnt_next  = CNT_W'(SQRT_STEPS);
            end
            ST_SQRT:
            begin
                rem_next  = sub_ge ? sub_diff[REM_W-1:0] : sub_a[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], sub_ge};
                v_next    = {v_reg[DQ_W-3:0], 2'b00};
                cnt_next  = cnt_reg - CNT_W'(1);
            end
            ST_TAN_LOAD:
            begin
                inf_next  = (root_reg == '0) || (root_reg < ROOT_W'(thr_reg));
                dq_next   = DQ_W'(smag) << FRAC_BITS;
                rem_next  = '0;
                divr_next = root_reg;
                cnt_next  = CNT_W'(DIV_STEPS);
            end
            default:
            begin
            end
        endcase

        sine_next = sine_sat;
        cos_next  = cneg ? OUT_W'(-cmag_ext) : OUT_W'(cmag_ext);
        tinf_next = inf_reg;
        if (inf_reg)
            tan_next = '0;
        else if (tneg)
        begin
            qsat     = (dq_reg > DQ_W'(33'h080000000)) ? (TAN_W + 1)'(33'h080000000)
                                                        : dq_reg[TAN_W:0];
            tan_next = TAN_W'(-qsat);
        end
        else
            tan_next = (dq_reg > DQ_W'(32'h7FFFFFFF)) ? TAN_W'(32'h7FFFFFFF)
                                                       : dq_reg[TAN_W-1:0];
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            tc_reg        <= TERM_COUNT_RST;
            thr_reg       <= COS_THRESH_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TERM_COUNT: tc_reg  <= cfg_data[TC_W-1:0];
                    REG_COS_THRESH: thr_reg <= cfg_data[THR_W-1:0];
                    default:        tc_reg  <= tc_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        x2_reg   <= x2_next;
        t_reg    <= t_next;
        sum_reg  <= sum_next;
        i_reg    <= i_next;
        n_reg    <= n_next;
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        divr_reg <= divr_next;
        v_reg    <= v_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
        inf_reg  <= inf_next;
        if (load_out)
        begin
            sine_reg <= sine_next;
            cos_reg  <= cos_next;
            tan_reg  <= tan_next;
            tinf_reg <= tinf_next;
        end
    end

endmodule
